// ===== rtl/core/knnbg_pkg.sv =====
// Shared types and constants of the per-pixel KNN background subtractor.
`default_nettype none

package knnbg_pkg;

  localparam int PIX_W      = 10;
  localparam int TEMP_W     = 16;
  localparam int DIST_W     = 16;
  localparam int SLOT_W     = 6;
  localparam int CNT_W      = 7;
  localparam int K_W        = 5;
  localparam int MINS_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Opcodes of an input request
  localparam logic [1:0] OP_DETECT = 2'd0;
  localparam logic [1:0] OP_LEARN  = 2'd1;
  localparam logic [1:0] OP_INIT   = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_DEPTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOUR_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES     = 3'd4;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [PIX_W-1:0]        pixel_index;
    logic signed [TEMP_W-1:0] temperature;
    logic                    masked;
    logic [6:0]              random_draw;
    logic                    frame_end;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]  result_pixel;
    logic              foreground;
    logic [DIST_W-1:0] mean_distance;
  } out_result_t;

  // Command handed from the front to the back
  typedef struct packed {
    logic                     is_detect;
    logic [PIX_W-1:0]         pixel;
    logic signed [TEMP_W-1:0] temperature;
    logic [SLOT_W-1:0]        slot;
    logic [CNT_W-1:0]         count;
  } cmd_t;

  // Settings the back uses for a detect
  typedef struct packed {
    logic [K_W-1:0]    k;
    logic [DIST_W-1:0] threshold;
    logic [MINS_W-1:0] min_samples;
  } back_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/knnbg_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module knnbg_div #(
  parameter int NW = 20,
  parameter int DW = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quot
);

  localparam int CW = $clog2(NW + 1);

  logic          run_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [NW-1:0] q_r;
  logic [DW:0]   trial;
  logic          fits;

  // Shift in the next numerator bit and try a subtract
  always_comb begin
    trial = {rem_r, q_r[NW-1]};
    fits  = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(NW);
      end else if (run_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      q_r   <= num;
    end else if (run_r) begin
      rem_r <= fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      q_r   <= {q_r[NW-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

// ===== rtl/core/knnbg_fifo.sv =====
// Four-entry command queue between front and back.
`default_nettype none

module knnbg_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire knnbg_pkg::cmd_t push_cmd,
  input  wire logic            pop,
  output knnbg_pkg::cmd_t      head,
  output logic                 empty,
  output logic                 full
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  knnbg_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [AW:0]     fill_r;
  logic            do_push;
  logic            do_pop;

  assign empty   = fill_r == '0;
  assign full    = fill_r == (AW+1)'(DEPTH);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + AW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + AW'(1);
      if (do_push && !do_pop) fill_r <= fill_r + (AW+1)'(1);
      else if (do_pop && !do_push) fill_r <= fill_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

`default_nettype wire

// ===== rtl/core/knnbg_front.sv =====
// Front: request intake, configuration, per-pixel count and ring table.
`default_nettype none

module knnbg_front #(
  parameter int PIXELS      = 768,
  parameter int MAX_HISTORY = 16,
  parameter int MAX_K       = 10
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire knnbg_pkg::in_item_t                 in_item,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [knnbg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [knnbg_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                     cmd_push,
  output knnbg_pkg::cmd_t                          cmd,
  input  wire logic                                fifo_full,
  input  wire logic                                drained,
  output knnbg_pkg::back_cfg_t                     back_cfg
);

  localparam int PW  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int MCW = $clog2(MAX_HISTORY + 1);
  localparam int MSW = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
  localparam int MKW = $clog2(MAX_K + 1);
  localparam int MW  = MCW + MSW;
  localparam int DEPTH_RST = (MAX_HISTORY < 16) ? MAX_HISTORY : 16;
  localparam int K_RST     = (MAX_K < 3) ? MAX_K : 3;
  localparam logic [31:0] PIX_LIM = 32'(PIXELS);

  typedef enum logic [4:0] {
    F_CLEAR   = 5'b00001,
    F_IDLE    = 5'b00010,
    F_EXEC    = 5'b00100,
    F_CLIP_RD = 5'b01000,
    F_CLIP_WR = 5'b10000
  } fstate_t;

  fstate_t state_r, state_nxt;
  logic [PW-1:0]  sweep_r;
  logic           sweep_last;

  logic [MCW-1:0] depth_r;
  logic [MKW-1:0] k_r;
  logic [6:0]     rate_r;
  logic [15:0]    thr_r;
  logic [4:0]     mins_r;
  logic           ready_r;

  knnbg_pkg::in_item_t item_r;

  logic [MW-1:0]  meta_mem [PIXELS];
  logic [MW-1:0]  meta_rd_r;
  logic [PW-1:0]  meta_raddr;
  logic [PW-1:0]  meta_waddr;
  logic [MW-1:0]  meta_wdata;
  logic           meta_we;

  logic           cfg_wr;
  logic           depth_wr;
  logic [7:0]     dv8;
  logic [7:0]     dn8;
  logic [7:0]     kv8;

  logic           pix_ok;
  logic [MCW-1:0] cur_cnt;
  logic [MSW-1:0] cur_ring;
  logic [MCW-1:0] ring_ext;
  logic [MCW-1:0] ring_fix;
  logic [MCW-1:0] ring_inc;
  logic [MCW-1:0] ring_nxt;
  logic           hist_full;
  logic [MCW-1:0] learn_slot;
  logic [MCW-1:0] learn_cnt;
  logic [MSW-1:0] learn_ring;
  logic           do_init;
  logic           do_learn;
  logic           do_det;
  logic [MCW-1:0] clip_cnt;
  logic [MSW-1:0] clip_ring;

  // Configuration write decode; accept only with nothing in flight
  assign cfg_ready = (state_r == F_CLEAR) || ((state_r == F_IDLE) && !start && drained);
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign dv8       = {3'd0, cfg_data[4:0]};
  assign dn8       = (dv8 > 8'(MAX_HISTORY)) ? 8'(MAX_HISTORY) : dv8;
  assign depth_wr  = cfg_wr && (cfg_index == knnbg_pkg::REG_HISTORY_DEPTH) && (dv8 != 8'd0);
  assign kv8       = (cfg_data[3:0] == 4'd0) ? 8'd1 :
                     (({4'd0, cfg_data[3:0]} > 8'(MAX_K)) ? 8'(MAX_K) : {4'd0, cfg_data[3:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= MCW'(DEPTH_RST);
      k_r     <= MKW'(K_RST);
      rate_r  <= 7'd5;
      thr_r   <= 16'd128;
      mins_r  <= 5'd1;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        knnbg_pkg::REG_HISTORY_DEPTH: begin
          if (dv8 != 8'd0) begin
            depth_r <= MCW'(dn8);
            if (8'(k_r) > dn8) k_r <= MKW'(dn8);
          end
        end
        knnbg_pkg::REG_NEIGHBOUR_COUNT: k_r    <= MKW'(kv8);
        knnbg_pkg::REG_LEARN_RATE:      rate_r <= cfg_data[6:0];
        knnbg_pkg::REG_THRESHOLD:       thr_r  <= cfg_data[15:0];
        knnbg_pkg::REG_MIN_SAMPLES:     mins_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign back_cfg.k           = knnbg_pkg::K_W'(k_r);
  assign back_cfg.threshold   = thr_r;
  assign back_cfg.min_samples = mins_r;

  // Classify the held request against its pixel's count and ring
  always_comb begin
    pix_ok     = {22'd0, item_r.pixel_index} < PIX_LIM;
    cur_cnt    = meta_rd_r[MW-1:MSW];
    cur_ring   = meta_rd_r[MSW-1:0];
    ring_ext   = MCW'(cur_ring);
    ring_fix   = (ring_ext >= depth_r) ? '0 : ring_ext;
    ring_inc   = ring_fix + MCW'(1);
    ring_nxt   = (ring_inc == depth_r) ? '0 : ring_inc;
    hist_full  = cur_cnt >= depth_r;
    learn_slot = hist_full ? ring_fix : cur_cnt;
    learn_cnt  = hist_full ? cur_cnt : cur_cnt + MCW'(1);
    learn_ring = hist_full ? MSW'(ring_nxt) : cur_ring;
    do_init    = (item_r.opcode == knnbg_pkg::OP_INIT) ||
                 ((item_r.opcode == knnbg_pkg::OP_LEARN) && !ready_r);
    do_learn   = (item_r.opcode == knnbg_pkg::OP_LEARN) && ready_r && !item_r.masked &&
                 (item_r.random_draw < rate_r);
    do_det     = item_r.opcode == knnbg_pkg::OP_DETECT;
    clip_cnt   = (cur_cnt > depth_r) ? depth_r : cur_cnt;
    clip_ring  = (ring_ext >= depth_r) ? '0 : cur_ring;
  end

  // Table port control
  always_comb begin
    meta_raddr = (state_r == F_IDLE) ? PW'(in_item.pixel_index) : sweep_r;
    meta_waddr = sweep_r;
    meta_wdata = '0;
    meta_we    = 1'b0;
    unique case (state_r)
      F_CLEAR: meta_we = 1'b1;
      F_EXEC: begin
        meta_waddr = PW'(item_r.pixel_index);
        meta_we    = pix_ok && (do_init || do_learn);
        meta_wdata = do_init ? {MCW'(1), MSW'(0)} : {learn_cnt, learn_ring};
      end
      F_CLIP_WR: begin
        meta_we    = 1'b1;
        meta_wdata = {clip_cnt, clip_ring};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
  end

  always_ff @(posedge clk) begin
    meta_rd_r <= meta_mem[meta_raddr];
  end

  // Command toward the back
  assign cmd_push        = (state_r == F_EXEC) && pix_ok && (do_init || do_learn || do_det);
  assign cmd.is_detect   = do_det;
  assign cmd.pixel       = item_r.pixel_index;
  assign cmd.temperature = item_r.temperature;
  assign cmd.slot        = do_init ? '0 : knnbg_pkg::SLOT_W'(learn_slot);
  assign cmd.count       = ready_r ? knnbg_pkg::CNT_W'(cur_cnt) : '0;

  assign busy       = (state_r != F_IDLE) || fifo_full;
  assign sweep_last = sweep_r == PW'(PIXELS - 1);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_CLEAR:   if (sweep_last) state_nxt = F_IDLE;
      F_IDLE: begin
        if (depth_wr) state_nxt = F_CLIP_RD;
        else if (start && !fifo_full) state_nxt = F_EXEC;
      end
      F_EXEC:    state_nxt = F_IDLE;
      F_CLIP_RD: state_nxt = F_CLIP_WR;
      F_CLIP_WR: if (sweep_last) state_nxt = F_IDLE; else state_nxt = F_CLIP_RD;
      default:   state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_CLEAR;
      sweep_r <= '0;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_CLEAR || state_r == F_CLIP_WR) begin
        sweep_r <= sweep_last ? '0 : sweep_r + PW'(1);
      end
      if (state_r == F_EXEC && do_init && item_r.frame_end) ready_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && start && !fifo_full) item_r <= in_item;
  end

  // Checks
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_EXEC) |-> !fifo_full) else $error("push with queue full");
  a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |=> ready_r) else $error("model ready dropped");
  a_detect_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_EXEC && item_r.opcode == knnbg_pkg::OP_DETECT) |-> !meta_we)
    else $error("detect wrote table");

endmodule

`default_nettype wire

// ===== rtl/core/knnbg_back.sv =====
// Back: sample history memory, k-nearest scan, mean and decision.
`default_nettype none

module knnbg_back #(
  parameter int PIXELS      = 768,
  parameter int MAX_HISTORY = 16,
  parameter int MAX_K       = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 fifo_empty,
  input  wire knnbg_pkg::cmd_t      head,
  output logic                      cmd_pop,
  input  wire knnbg_pkg::back_cfg_t cfg,
  output logic                      idle,
  output logic                      out_strobe,
  output knnbg_pkg::out_result_t    out_result
);

  localparam int HD   = PIXELS * MAX_HISTORY;
  localparam int HAW  = (HD > 1) ? $clog2(HD) : 1;
  localparam int MCW  = $clog2(MAX_HISTORY + 1);
  localparam int MSW  = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
  localparam int MKW  = $clog2(MAX_K + 1);
  localparam int SUMW = 16 + MKW;

  typedef enum logic [6:0] {
    B_IDLE   = 7'b0000001,
    B_SCAN   = 7'b0000010,
    B_LAST   = 7'b0000100,
    B_SUM    = 7'b0001000,
    B_DSTART = 7'b0010000,
    B_DIV    = 7'b0100000,
    B_OUT    = 7'b1000000
  } bstate_t;

  bstate_t state_r, state_nxt;

  logic [15:0]    hist_mem [HD];
  logic [15:0]    hist_rd_r;
  logic           rv_r;
  logic [HAW-1:0] base_r;
  logic [HAW-1:0] rd_addr;
  logic [HAW-1:0] wr_addr;
  logic           hist_we;

  logic [knnbg_pkg::PIX_W-1:0] pix_r;
  logic signed [15:0] temp_r;
  logic [MCW-1:0] n_r;
  logic [MSW-1:0] ptr_r;
  logic           scan_last;
  logic [MKW-1:0] kuse_r;
  logic [MKW-1:0] cnt_r;
  logic [SUMW-1:0] sum_r;
  logic [15:0]    best_r [MAX_K];
  logic [15:0]    mean_r;
  logic           fg_r;

  logic signed [16:0] diff;
  logic [15:0]    abs_diff;
  logic [7:0]     k8;
  logic [7:0]     n8;
  logic [7:0]     kuse8;
  logic           div_done;
  logic [SUMW-1:0] quot;
  logic [15:0]    mean_sat;

  // History memory ports
  assign wr_addr = HAW'(32'(head.pixel) * MAX_HISTORY + 32'(head.slot));
  assign hist_we = (state_r == B_IDLE) && !fifo_empty && !head.is_detect;
  assign rd_addr = base_r + HAW'(ptr_r);

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[wr_addr] <= head.temperature;
  end

  always_ff @(posedge clk) begin
    hist_rd_r <= hist_mem[rd_addr];
  end

  assign cmd_pop   = (state_r == B_IDLE) && !fifo_empty;
  assign idle      = state_r == B_IDLE;
  assign scan_last = MCW'(ptr_r) == n_r - MCW'(1);

  // Neighbour count clipped to the samples present
  assign k8    = {3'd0, cfg.k};
  assign n8    = 8'(head.count);
  assign kuse8 = (k8 < n8) ? k8 : n8;

  // Distance of the returning sample
  assign diff     = {temp_r[15], temp_r} - {hist_rd_r[15], hist_rd_r};
  assign abs_diff = diff[16] ? 16'(-diff) : diff[15:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!fifo_empty && head.is_detect) begin
          state_nxt = (head.count == '0) ? B_OUT : B_SCAN;
        end
      end
      B_SCAN:   if (scan_last) state_nxt = B_LAST;
      B_LAST:   state_nxt = B_SUM;
      B_SUM:    if (cnt_r == kuse_r - MKW'(1)) state_nxt = B_DSTART;
      B_DSTART: state_nxt = B_DIV;
      B_DIV:    if (div_done) state_nxt = B_OUT;
      B_OUT:    state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= state_r == B_SCAN;
    end
  end

  assign mean_sat = (quot > SUMW'(16'hFFFF)) ? 16'hFFFF : quot[15:0];

  // Detect datapath
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        pix_r  <= head.pixel;
        temp_r <= head.temperature;
        n_r    <= MCW'(head.count);
        base_r <= HAW'(32'(head.pixel) * MAX_HISTORY);
        kuse_r <= MKW'(kuse8);
        ptr_r  <= '0;
        mean_r <= '0;
        fg_r   <= 1'b0;
        for (int i = 0; i < MAX_K; i++) best_r[i] <= '1;
      end
      B_SCAN: ptr_r <= ptr_r + MSW'(1);
      B_SUM: begin
        sum_r <= sum_r + SUMW'(best_r[0]);
        cnt_r <= cnt_r + MKW'(1);
        for (int i = 0; i < MAX_K - 1; i++) best_r[i] <= best_r[i+1];
        best_r[MAX_K-1] <= '1;
      end
      B_DIV: begin
        if (div_done) begin
          mean_r <= mean_sat;
          fg_r   <= (8'(kuse_r) >= {3'd0, cfg.min_samples}) && (mean_sat > cfg.threshold);
        end
      end
      default: ;
    endcase
    if (state_r == B_LAST) begin
      sum_r <= '0;
      cnt_r <= '0;
    end
    // Insert into the sorted nearest list
    if (rv_r) begin
      for (int i = 0; i < MAX_K; i++) begin
        if (abs_diff < best_r[i]) begin
          if (i == 0) best_r[i] <= abs_diff;
          else if (abs_diff >= best_r[i-1]) best_r[i] <= abs_diff;
          else best_r[i] <= best_r[i-1];
        end
      end
    end
  end

  knnbg_div #(.NW(SUMW), .DW(MKW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == B_DSTART),
    .num   (sum_r),
    .den   (kuse_r),
    .done  (div_done),
    .quot  (quot)
  );

  assign out_strobe               = state_r == B_OUT;
  assign out_result.result_pixel  = pix_r;
  assign out_result.foreground    = fg_r;
  assign out_result.mean_distance = mean_r;

  // Checks
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SUM) |-> (cnt_r < kuse_r && MCW'(kuse_r) <= n_r))
    else $error("sum beyond neighbour count");
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result strobe repeated");

endmodule

`default_nettype wire

// ===== rtl/core/knn_pixel_background_subtractor.sv =====
// Top level of the per-pixel KNN background subtractor.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------
//  input    | start / busy         | in_item   (opcode, pixel, sample...)
//  result   | out_strobe           | out_result (pixel, fg, mean dist)
//  config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Front reads the table for a request, then classifies it and updates the table.
// Detect in the back runs the history scan at one sample a cycle, sums the k
// nearest distances and takes their mean with the bit-serial divider.
// After reset a clearing pass runs with busy high and cfg_ready high; a nonzero
// history_depth write runs a trimming pass with cfg_ready low.
// Otherwise cfg_ready is low while any request is in flight or start is high.
// The result side cannot stall; results leave on out_strobe for one cycle.
`default_nettype none

module knn_pixel_background_subtractor #(
  parameter int PIXELS      = 768,
  parameter int MAX_HISTORY = 16,
  parameter int MAX_K       = 10
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire knnbg_pkg::in_item_t              in_item,
  output logic                                  out_strobe,
  output knnbg_pkg::out_result_t                out_result,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [knnbg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [knnbg_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                 cmd_push;
  knnbg_pkg::cmd_t      cmd_in;
  knnbg_pkg::cmd_t      cmd_head;
  logic                 cmd_pop;
  logic                 fifo_empty;
  logic                 fifo_full;
  logic                 back_idle;
  logic                 drained;
  knnbg_pkg::back_cfg_t back_cfg;

  // Nothing queued and the back has finished its last request
  assign drained = fifo_empty && back_idle;

  knnbg_front #(.PIXELS(PIXELS), .MAX_HISTORY(MAX_HISTORY), .MAX_K(MAX_K)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in),
    .fifo_full (fifo_full),
    .drained   (drained),
    .back_cfg  (back_cfg)
  );

  knnbg_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .pop      (cmd_pop),
    .head     (cmd_head),
    .empty    (fifo_empty),
    .full     (fifo_full)
  );

  knnbg_back #(.PIXELS(PIXELS), .MAX_HISTORY(MAX_HISTORY), .MAX_K(MAX_K)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .head       (cmd_head),
    .cmd_pop    (cmd_pop),
    .cfg        (back_cfg),
    .idle       (back_idle),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

endmodule

`default_nettype wire
